FILE: src/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: sizes, command and
// status codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH   = 128;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic exec;
        logic read;
        logic load;
    } t_ctrl;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: src/cdq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_if
// Request and response channels of the circular deque, valid/ready style.
// ----------------------------------------------------------------------------
interface cdq_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [7:0]         count;
    logic               is_empty;
    logic               is_full;

    modport source (output valid, output status, output front_value, output back_value,
                    output count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input count, input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

FILE: src/cdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: accepts a request, sequences the store read and the load of
// the response register.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_ctrl         o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.exec = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_ctrl.read = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (!i_stat.out_valid || i_out_ready) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/cdq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dpath
// Datapath: circular store, head/tail indices, entry count and the
// response register.
// ----------------------------------------------------------------------------
module cdq_dpath
    import cdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl             i_ctrl,
    input  wire logic [1:0]        i_cmd,
    input  wire logic signed [31:0] i_value,
    input  wire logic              i_out_ready,
    output t_dp_stat               o_stat,
    output logic [1:0]             o_status,
    output logic signed [VAL_W-1:0] o_front_value,
    output logic signed [VAL_W-1:0] o_back_value,
    output logic [COUNT_W-1:0]     o_count,
    output logic                   o_is_empty,
    output logic                   o_is_full
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [IDX_W-1:0]  r_tail;
    logic [IDX_W-1:0]  n_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_status           r_status;
    t_status           n_status;

    logic [DATA_W-1:0] r_rd_front;
    logic [DATA_W-1:0] r_rd_back;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic signed [VAL_W-1:0] r_out_front;
    logic signed [VAL_W-1:0] r_out_back;
    logic [COUNT_W-1:0]      r_out_count;
    logic                    r_out_empty;
    logic                    r_out_full;

    t_cmd              cmd;
    logic              is_push;
    logic              is_full;
    logic              is_empty;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_dec;
    logic [IDX_W-1:0]  tail_inc;
    logic              rd_empty;

    assign cmd      = t_cmd'(i_cmd);
    assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_dec = (r_tail == '0) ? IDX_W'(DEPTH - 1) : r_tail - 1'b1;
    assign tail_inc = (r_tail == IDX_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = '0;
        if (i_ctrl.exec) begin
            n_status = ST_DONE;
            if (is_push) begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (is_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (cmd == CMD_PUSH_FRONT) begin
                        n_head  = head_dec;
                        wr_addr = head_dec;
                    end else begin
                        n_tail  = tail_inc;
                        wr_addr = tail_inc;
                    end
                end
            end else begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end else if (cmd == CMD_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        n_tail = tail_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.read) begin
            r_rd_front <= r_mem[r_head];
            r_rd_back  <= r_mem[r_tail];
        end
    end

    assign rd_empty = is_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_out_status <= r_status;
            r_out_front  <= rd_empty ? '1 : VAL_W'($signed(r_rd_front));
            r_out_back   <= rd_empty ? '1 : VAL_W'($signed(r_rd_back));
            r_out_count  <= COUNT_W'(r_count);
            r_out_empty  <= rd_empty;
            r_out_full   <= is_full;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_status         = r_out_status;
    assign o_front_value    = r_out_front;
    assign o_back_value     = r_out_back;
    assign o_count          = r_out_count;
    assign o_is_empty       = r_out_empty;
    assign o_is_full        = r_out_full;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_empty_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> (r_out_front == '1) && (r_out_back == '1))
        else $error("empty response without sentinel values");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.exec && is_push && !is_full |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow count");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.exec && (n_status != ST_DONE)
        |=> $stable(r_count) && $stable(r_head) && $stable(r_tail))
        else $error("rejected request changed deque state");

endmodule
`default_nettype wire

FILE: src/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// Fixed-capacity double-ended queue of 32-bit signed words in a circular
// store, with push/pop at either end and one response per request.
// ----------------------------------------------------------------------------
// A request passes three steps: the accept cycle updates the indices and
// count and writes the store, the next cycle reads the front and back entries
// through the store's two registered read ports, and the third loads the
// response register. The response register holds a finished response until it
// is taken while the next request is already accepted; a new response is
// loaded once the previous one has gone.
module circular_deque_unit
    import cdq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdq_req_if.sink    i_req,
    cdq_rsp_if.source  o_rsp
);

    t_ctrl    ctrl;
    t_dp_stat stat;
    logic     in_ready;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_ctrl      (ctrl)
    );

    cdq_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cmd         (i_req.cmd),
        .i_value       (i_req.value),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (stat),
        .o_status      (o_rsp.status),
        .o_front_value (o_rsp.front_value),
        .o_back_value  (o_rsp.back_value),
        .o_count       (o_rsp.count),
        .o_is_empty    (o_rsp.is_empty),
        .o_is_full     (o_rsp.is_full)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = stat.out_valid;

endmodule
`default_nettype wire

FILE: dv/tb_circular_deque_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_unit
// Self-checking bench for the circular deque. A table of directed requests
// covers the empty boundary and the data extremes. Random traffic follows,
// with fill, drain and mixed runs. Every response is compared field by field
// against an in-bench deque predictor, or the expected view of a pinned table
// row. Sender bursts and receiver stalls are randomized throughout.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;
    import cdq_pkg::*;

    localparam int RANDOM_REQUESTS = 800;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   front_value;
        logic [VAL_W-1:0]   back_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
    } t_deque_view;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] value;
        logic        pinned;
        t_deque_view view;
    } t_stim_row;

    logic clk;
    logic rst_n;

    cdq_req_if req_bus();
    cdq_rsp_if rsp_bus();

    circular_deque_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [DATA_W-1:0] deque_words [DEPTH];
    logic [IDX_W-1:0]  front_idx;
    logic [IDX_W-1:0]  back_idx;
    logic [CNT_W-1:0]  held;

    t_deque_view expected_views [$];
    t_stim_row   directed_rows [$];
    logic        pin_next;
    t_deque_view pinned_view;

    int sent_count;
    int resp_count;
    int error_count;
    int full_rejects;
    int empty_rejects;
    int peak_held;
    int burst_left;
    int cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [VAL_W-1:0] widen_word(logic [DATA_W-1:0] w);
        logic signed [DATA_W-1:0] s;
        s = w;
        return VAL_W'(s);
    endfunction

    task automatic update_deque(input t_cmd c, input logic [31:0] v,
                                output t_deque_view view);
        view.status = ST_DONE;
        if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) begin
            if (held >= DEPTH) begin
                view.status = ST_FULL;
            end else begin
                if (held == 0) begin
                    front_idx = '0;
                    back_idx  = '0;
                    deque_words[0] = v[DATA_W-1:0];
                end else if (c == CMD_PUSH_FRONT) begin
                    front_idx = (front_idx == 0) ? IDX_W'(DEPTH - 1) : front_idx - 1'b1;
                    deque_words[front_idx] = v[DATA_W-1:0];
                end else begin
                    back_idx = (back_idx == IDX_W'(DEPTH - 1)) ? '0 : back_idx + 1'b1;
                    deque_words[back_idx] = v[DATA_W-1:0];
                end
                held = held + 1'b1;
            end
        end else begin
            if (held == 0) begin
                view.status = ST_EMPTY;
            end else begin
                if (held == 1) begin
                    front_idx = '0;
                    back_idx  = '0;
                end else if (c == CMD_POP_FRONT) begin
                    front_idx = (front_idx == IDX_W'(DEPTH - 1)) ? '0 : front_idx + 1'b1;
                end else begin
                    back_idx = (back_idx == 0) ? IDX_W'(DEPTH - 1) : back_idx - 1'b1;
                end
                held = held - 1'b1;
            end
        end
        if (held == 0) begin
            view.front_value = '1;
            view.back_value  = '1;
        end else begin
            view.front_value = widen_word(deque_words[front_idx]);
            view.back_value  = widen_word(deque_words[back_idx]);
        end
        view.count    = COUNT_W'(held);
        view.is_empty = (held == 0);
        view.is_full  = (held >= DEPTH);
    endtask

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR: response %0d: %s", resp_count, msg);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            report_error($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    always @(posedge clk) begin
        t_deque_view want;
        t_deque_view next_view;
        if (rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                resp_count++;
                if (expected_views.size() == 0) begin
                    report_error("response with no request outstanding");
                end else begin
                    want = expected_views.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp_bus.status));
                    compare_field("front_value", want.front_value, rsp_bus.front_value);
                    compare_field("back_value", want.back_value, rsp_bus.back_value);
                    compare_field("count", 32'(want.count), 32'(rsp_bus.count));
                    compare_field("is_empty", 32'(want.is_empty), 32'(rsp_bus.is_empty));
                    compare_field("is_full", 32'(want.is_full), 32'(rsp_bus.is_full));
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                update_deque(t_cmd'(req_bus.cmd), req_bus.value, next_view);
                if (next_view.status == ST_FULL)
                    full_rejects++;
                if (next_view.status == ST_EMPTY)
                    empty_rejects++;
                if (held > peak_held)
                    peak_held = held;
                if (pin_next)
                    next_view = pinned_view;
                expected_views.push_back(next_view);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_views.size());
            $display("circular_deque_unit: mismatch");
            $finish;
        end
    end

    initial begin : rsp_stalls
        int stall_left;
        int mode_left;
        int mode;
        rsp_bus.ready = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        mode       = 0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(100, 400);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if ((mode == 1 && $urandom_range(0, 99) < 20) ||
                         (mode == 2 && $urandom_range(0, 99) < 50)) begin
                stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                         : $urandom_range(1, 4);
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cmd pick_cmd(int push_pct);
        logic side;
        side = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            return side ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return side ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    function automatic void add_row(t_cmd c, logic [31:0] v, logic pinned = 1'b0,
                                    t_status st = ST_DONE, logic [31:0] fv = '0,
                                    logic [31:0] bv = '0, logic [7:0] cnt = '0,
                                    logic emp = 1'b0, logic ful = 1'b0);
        t_stim_row row;
        row.cmd              = c;
        row.value            = v;
        row.pinned           = pinned;
        row.view.status      = st;
        row.view.front_value = fv;
        row.view.back_value  = bv;
        row.view.count       = cnt;
        row.view.is_empty    = emp;
        row.view.is_full     = ful;
        directed_rows.push_back(row);
    endfunction

    // hold at a falling edge, sometimes with valid dropped for a random gap
    task automatic pace();
        int gap;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_request(t_cmd c, logic [31:0] v, logic pinned, t_deque_view pv);
        req_bus.valid <= 1'b1;
        req_bus.cmd   <= c;
        req_bus.value <= v;
        pin_next    = pinned;
        pinned_view = pv;
        @(posedge clk);
        while (!(req_bus.valid && req_bus.ready)) @(posedge clk);
        sent_count++;
        pace();
    endtask

    task automatic run_mix(int n, int push_pct);
        repeat (n) send_request(pick_cmd(push_pct), random_word(), 1'b0, '0);
    endtask

    task automatic fill_to_full();
        while (held < DEPTH) send_request(pick_cmd(100), random_word(), 1'b0, '0);
        run_mix(4, 100);
    endtask

    task automatic drain_to_empty();
        while (held != 0) send_request(pick_cmd(0), random_word(), 1'b0, '0);
        run_mix(3, 0);
    endtask

    task automatic pause_until_drained();
        req_bus.valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin : stimulus
        int total;
        int fails;
        rst_n         = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.cmd   = CMD_PUSH_FRONT;
        req_bus.value = '0;
        pin_next      = 1'b0;
        pinned_view   = '0;
        front_idx     = '0;
        back_idx      = '0;
        held          = '0;
        sent_count    = 0;
        resp_count    = 0;
        error_count   = 0;
        full_rejects  = 0;
        empty_rejects = 0;
        peak_held     = 0;
        burst_left    = 0;
        cycle_count   = 0;

        add_row(CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY, '1, '1, 8'd0, 1'b1, 1'b0);
        add_row(CMD_POP_BACK,   32'h0000_1234, 1'b1, ST_EMPTY, '1, '1, 8'd0, 1'b1, 1'b0);
        add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_DONE,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd1, 1'b0, 1'b0);
        add_row(CMD_PUSH_BACK,  32'h8000_0000, 1'b1, ST_DONE,
                32'h7FFF_FFFF, 32'h8000_0000, 8'd2, 1'b0, 1'b0);
        add_row(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        add_row(CMD_PUSH_BACK,  32'h0000_0000);
        add_row(CMD_POP_BACK,   32'h0000_0000);
        add_row(CMD_POP_FRONT,  32'hFFFF_FFFF);
        add_row(CMD_POP_BACK,   32'h8000_0000);
        add_row(CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE, '1, '1, 8'd0, 1'b1, 1'b0);
        add_row(CMD_PUSH_BACK,  32'h5555_5555);
        add_row(CMD_PUSH_BACK,  32'hAAAA_AAAA);
        add_row(CMD_PUSH_FRONT, 32'h0000_0001);
        add_row(CMD_POP_FRONT,  32'h0000_0000);
        add_row(CMD_POP_FRONT,  32'h0000_0000);
        add_row(CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE, '1, '1, 8'd0, 1'b1, 1'b0);
        add_row(CMD_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY, '1, '1, 8'd0, 1'b1, 1'b0);
        add_row(CMD_PUSH_BACK,  32'h8000_0000, 1'b1, ST_DONE,
                32'h8000_0000, 32'h8000_0000, 8'd1, 1'b0, 1'b0);
        add_row(CMD_POP_BACK,   32'h8000_0000, 1'b1, ST_DONE, '1, '1, 8'd0, 1'b1, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].value,
                         directed_rows[i].pinned, directed_rows[i].view);

        total = directed_rows.size() + RANDOM_REQUESTS;
        fill_to_full();
        pause_until_drained();
        drain_to_empty();
        while (sent_count < total) begin
            case ($urandom_range(0, 5))
                0: fill_to_full();
                1: drain_to_empty();
                2: run_mix($urandom_range(10, 40), 75);
                3: run_mix($urandom_range(10, 40), 25);
                default: run_mix($urandom_range(10, 60), 50);
            endcase
            if ($urandom_range(0, 5) == 0)
                pause_until_drained();
        end

        req_bus.valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fails = error_count + expected_views.size();

        $display("run: %0d requests, %0d responses, refused: %0d when full, %0d when empty",
                 sent_count, resp_count, full_rejects, empty_rejects);
        $display("run: occupancy peaked at %0d of %0d entries, %0d errors",
                 peak_held, DEPTH, fails);
        if (fails == 0) begin
            $display("circular_deque_unit: match");
        end else begin
            $display("circular_deque_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ctrl.sv
src/cdq_dpath.sv
src/circular_deque_unit.sv
dv/tb_circular_deque_unit.sv
